### rtl/hgo_pkg.sv
`timescale 1ns / 1ps
package hgo_pkg;

  localparam int CW          = 12;   // coordinate width
  localparam int PW          = 11;   // clamped pitch width
  localparam int DIV_BITS    = 2;    // quotient bits per divider stage
  localparam int DIV_STAGES  = CW / DIV_BITS;
  localparam int HASH_STAGES = 9;
  localparam int AXIS_STAGES = DIV_STAGES + HASH_STAGES;
  localparam int LIMIT_W     = 17;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 13;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GRID_SIZE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WHITE_MODE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_H_KEEP      = 3'd2;
  localparam logic [IDX_W-1:0] REG_V_KEEP      = 3'd3;
  localparam logic [IDX_W-1:0] REG_LINE_BLEND  = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAME_H     = 3'd5;
  localparam logic [IDX_W-1:0] REG_DARK_LUMA   = 3'd6;
  localparam logic [IDX_W-1:0] REG_BRIGHT_LUMA = 3'd7;

  // hash multipliers
  localparam logic [31:0] K_S   = 32'd374761393;
  localparam logic [31:0] K_N   = 32'd668265263;
  localparam logic [31:0] K_P   = 32'd2246822519;
  localparam logic [63:0] K_SALT64 = 64'd3266489917;
  localparam logic [31:0] K_MIX = 32'd1274126177;

  // salt terms, salt * K_SALT mod 2^32
  localparam logic [31:0] TERM_KEEP_H  = 32'(64'd17 * K_SALT64);
  localparam logic [31:0] TERM_KEEP_V  = 32'(64'd29 * K_SALT64);
  localparam logic [31:0] TERM_LEVEL_H = 32'(64'd228 * K_SALT64);
  localparam logic [31:0] TERM_LEVEL_V = 32'(64'd240 * K_SALT64);

  typedef struct packed {
    logic [PW-1:0] pitch;
    logic [31:0]   pitch_term;
    logic [7:0]    strength;
    logic [7:0]    cliff;
  } hgo_shared_t;

  // min of the period-4 and period-8 energies, indexed by position mod 8
  function automatic logic [7:0] edge_energy(input logic [2:0] m);
    logic [7:0] e;
    case (m)
      3'd0: e = 8'd37;
      3'd1: e = 8'd110;
      3'd2: e = 8'd183;
      3'd3: e = 8'd85;
      3'd4: e = 8'd85;
      3'd5: e = 8'd183;
      3'd6: e = 8'd110;
      default: e = 8'd37;
    endcase
    return e;
  endfunction

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

### rtl/hgo_axis.sv
`timescale 1ns / 1ps
module hgo_axis (
  input  logic                                   clk,
  input  logic [hgo_pkg::AXIS_STAGES-1:0]        en,
  input  logic [hgo_pkg::CW-1:0]                 coord,
  input  hgo_pkg::hgo_shared_t                   shared,
  input  logic [6:0]                             density,
  input  logic [hgo_pkg::LIMIT_W-1:0]            limit,
  input  logic                                   vertical,
  output logic [7:0]                             level
);
  import hgo_pkg::*;

  localparam int H1 = DIV_STAGES;

  logic [7:0] dmg;
  logic       full_on;
  logic       den_low;
  assign dmg     = ~shared.strength;
  assign full_on = (density == 7'd100) && (shared.strength == 8'd255);
  assign den_low = density < 7'd100;

  // ---- pipelined restoring divider
  logic [CW-1:0] dc [0:DIV_STAGES-1];
  logic [PW-1:0] dr [0:DIV_STAGES-1];
  logic [CW-1:0] dq [0:DIV_STAGES-1];
  logic [CW-1:0] sc [0:DIV_STAGES-1];
  logic [PW-1:0] sr [0:DIV_STAGES-1];
  logic [CW-1:0] sq [0:DIV_STAGES-1];
  logic [PW-1:0] nr [0:DIV_STAGES-1];
  logic [CW-1:0] nq [0:DIV_STAGES-1];

  always_comb begin
    logic [PW:0] t;
    sc[0] = coord;
    sr[0] = '0;
    sq[0] = '0;
    for (int j = 1; j < DIV_STAGES; j++) begin
      sc[j] = dc[j-1];
      sr[j] = dr[j-1];
      sq[j] = dq[j-1];
    end
    for (int j = 0; j < DIV_STAGES; j++) begin
      nr[j] = sr[j];
      nq[j] = sq[j];
      for (int b = 0; b < DIV_BITS; b++) begin
        t = {nr[j], sc[j][CW-1-j*DIV_BITS-b]};
        if (t >= {1'b0, shared.pitch}) begin
          t = t - {1'b0, shared.pitch};
          nq[j][CW-1-j*DIV_BITS-b] = 1'b1;
        end
        nr[j] = t[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[j]) begin
        dc[j] <= sc[j];
        dr[j] <= nr[j];
        dq[j] <= nq[j];
      end
    end
  end

  // ---- h1: line start, offset flags, index term
  logic [CW-1:0] start1;
  logic          off1_1, hit1;
  logic [31:0]   nterm1;
  logic [PW-1:0] rem_d;
  assign rem_d = dr[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (en[H1]) begin
      start1 <= dc[DIV_STAGES-1] - CW'(rem_d);
      off1_1 <= rem_d == PW'(1);
      hit1   <= ((rem_d == '0) ||
                 ((rem_d == PW'(1)) &&
                  ({{(LIMIT_W-CW){1'b0}}, dc[DIV_STAGES-1]} < limit))) &&
                (density != 7'd0);
      nterm1 <= 32'({{(32-CW){1'b0}}, dq[DIV_STAGES-1]} * K_N);
    end
  end

  // ---- h2: hash base sum, edge energies
  logic [31:0] base2;
  logic [7:0]  e0_2, e1_2;
  logic        off1_2, hit2;

  always_ff @(posedge clk) begin
    if (en[H1+1]) begin
      base2  <= 32'({{(32-CW){1'b0}}, start1} * K_S) + nterm1 + shared.pitch_term;
      e0_2   <= edge_energy(start1[2:0]);
      e1_2   <= edge_energy(start1[2:0] + 3'd1);
      off1_2 <= off1_1;
      hit2   <= hit1;
    end
  end

  // ---- h3: salt and first xor-shift, energy terms
  logic [31:0] ka3, la3;
  logic [6:0]  prank3;
  logic [7:0]  weak0_3, weak1_3, t1_0_3, t1_1_3;
  logic        off1_3, hit3;
  logic [31:0] ka_c, la_c;
  logic [8:0]  esum;
  logic [15:0] wp0, wp1;

  always_comb begin
    ka_c = base2 + (vertical ? TERM_KEEP_V : TERM_KEEP_H);
    la_c = base2 + (vertical ? TERM_LEVEL_V : TERM_LEVEL_H);
    esum = {1'b0, e0_2} + {1'b0, e1_2};
    wp0  = {8'd0, ~e0_2} * 16'd150;
    wp1  = {8'd0, ~e1_2} * 16'd150;
  end

  always_ff @(posedge clk) begin
    if (en[H1+2]) begin
      ka3     <= ka_c ^ (ka_c >> 13);
      la3     <= la_c ^ (la_c >> 13);
      prank3  <= 7'(div255({8'd0, esum[8:1]} * 16'd100));
      weak0_3 <= ~e0_2;
      weak1_3 <= ~e1_2;
      t1_0_3  <= 8'd32 + wp0[15:8];
      t1_1_3  <= 8'd32 + wp1[15:8];
      off1_3  <= off1_2;
      hit3    <= hit2;
    end
  end

  // ---- h4: hash multiply, tonal loss
  logic [31:0] ka4, la4;
  logic [6:0]  prank4;
  logic [7:0]  weak0_4, weak1_4, tonal0_4, tonal1_4;
  logic        off1_4, hit4;
  logic [15:0] tp0, tp1;

  always_comb begin
    tp0 = {8'd0, dmg} * {8'd0, t1_0_3};
    tp1 = {8'd0, dmg} * {8'd0, t1_1_3};
  end

  always_ff @(posedge clk) begin
    if (en[H1+3]) begin
      ka4      <= ka3 * K_MIX;
      la4      <= la3 * K_MIX;
      prank4   <= prank3;
      weak0_4  <= weak0_3;
      weak1_4  <= weak1_3;
      tonal0_4 <= tp0[15:8];
      tonal1_4 <= tp1[15:8];
      off1_4   <= off1_3;
      hit4     <= hit3;
    end
  end

  // ---- h5: final xor-shift, keep rank sum, grain, rank sums
  logic [13:0] xk5;
  logic [6:0]  grain0_5, grain1_5;
  logic [10:0] x6_0_5, x6_1_5;
  logic [4:0]  sp5;
  logic [7:0]  tonal0_5, tonal1_5;
  logic        off1_5, hit5;
  logic [31:0] hk, hv;
  logic [6:0]  jit;
  logic [7:0]  nz0, nz1;
  logic [15:0] gp0, gp1;

  always_comb begin
    hk  = ka4 ^ (ka4 >> 16);
    hv  = la4 ^ (la4 >> 16);
    jit = hk[30:24] & 7'd99;
    nz0 = hv[15:8];
    nz1 = hv[26:19];
    gp0 = {8'd0, nz0} * {8'd0, dmg};
    gp1 = {8'd0, nz1} * {8'd0, dmg};
  end

  always_ff @(posedge clk) begin
    if (en[H1+4]) begin
      xk5      <= {7'd0, prank4} * 14'd68 + {2'd0, jit, 5'd0};
      grain0_5 <= gp0[15:9];
      grain1_5 <= gp1[15:9];
      x6_0_5   <= {3'd0, weak0_4} * 11'd5 + {3'd0, nz0};
      x6_1_5   <= {3'd0, weak1_4} * 11'd5 + {3'd0, nz1};
      sp5      <= hv[7:3];
      tonal0_5 <= tonal0_4;
      tonal1_5 <= tonal1_4;
      off1_5   <= off1_4;
      hit5     <= hit4;
    end
  end

  // ---- h6: divide by 100 and by 6, raw levels
  logic               keep6;
  logic [8:0]         rank0_6, rank1_6;
  logic signed [9:0]  lvb0_6, lvb1_6;
  logic [4:0]         sp6;
  logic               off1_6, hit6;
  logic [26:0]        kp, rp0, rp1;

  always_comb begin
    kp  = {13'd0, xk5} * 27'd5243;
    rp0 = {16'd0, x6_0_5} * 27'd43691;
    rp1 = {16'd0, x6_1_5} * 27'd43691;
  end

  always_ff @(posedge clk) begin
    if (en[H1+5]) begin
      keep6   <= kp[26:19] < {1'b0, density};
      rank0_6 <= rp0[26:18];
      rank1_6 <= rp1[26:18];
      lvb0_6  <= 10'sd255 - signed'({2'b0, tonal0_5}) - signed'({3'b0, grain0_5});
      lvb1_6  <= 10'sd255 - signed'({2'b0, tonal1_5}) - signed'({3'b0, grain1_5});
      sp6     <= sp5;
      off1_6  <= off1_5;
      hit6    <= hit5;
    end
  end

  // ---- h7: cliff cut and floor
  logic [7:0]        lv0_7, lv1_7;
  logic [4:0]        sp7;
  logic              keep7, off1_7, hit7;
  logic signed [9:0] cut, lv0_c, lv1_c;
  logic              big_cliff;

  always_comb begin
    big_cliff = shared.cliff > 8'd96;
    cut   = signed'({2'b0, shared.cliff} - 10'd80);
    lv0_c = lvb0_6;
    lv1_c = lvb1_6;
    if (big_cliff && ({1'b0, rank0_6} > 10'd384 - {2'b0, shared.cliff})) lv0_c = lvb0_6 - cut;
    if (big_cliff && ({1'b0, rank1_6} > 10'd384 - {2'b0, shared.cliff})) lv1_c = lvb1_6 - cut;
  end

  always_ff @(posedge clk) begin
    if (en[H1+6]) begin
      lv0_7  <= (lv0_c < 10'sd18) ? 8'd0 : lv0_c[7:0];
      lv1_7  <= (lv1_c < 10'sd18) ? 8'd0 : lv1_c[7:0];
      sp7    <= sp6;
      keep7  <= keep6;
      off1_7 <= off1_6;
      hit7   <= hit6;
    end
  end

  // ---- h8: spread between the two offsets of a line
  logic [7:0]  lvsel8;
  logic        keep8, hit8;
  logic [9:0]  lim0, lim1;
  logic [15:0] m0, m1;
  logic [7:0]  lv0_s, lv1_s;
  logic        both;

  always_comb begin
    both  = (lv0_7 != 8'd0) && (lv1_7 != 8'd0);
    lim0  = {2'b0, lv1_7} + 10'd48 + {5'd0, sp7};
    lim1  = {2'b0, lv0_7} + 10'd48 + {5'd0, sp7};
    m0    = {8'd0, lv0_7} * (16'd160 + {11'd0, sp7});
    m1    = {8'd0, lv1_7} * (16'd160 + {11'd0, sp7});
    lv0_s = lv0_7;
    lv1_s = lv1_7;
    if (both && ({2'b0, lv0_7} > lim0)) lv1_s = m1[15:8];
    else if (both && ({2'b0, lv1_7} > lim1)) lv0_s = m0[15:8];
  end

  always_ff @(posedge clk) begin
    if (en[H1+7]) begin
      lvsel8 <= off1_7 ? lv1_s : lv0_s;
      keep8  <= keep7;
      hit8   <= hit7;
    end
  end

  // ---- h9: fast paths and keep decision
  always_ff @(posedge clk) begin
    if (en[H1+8]) begin
      if (!hit8)                        level <= 8'd0;
      else if (full_on)                 level <= 8'd255;
      else if (den_low && !keep8)       level <= 8'd0;
      else if (shared.strength == 8'hFF) level <= 8'd255;
      else                              level <= lvsel8;
    end
  end

endmodule

### rtl/hgo_blend.sv
`timescale 1ns / 1ps
module hgo_blend (
  input  logic       clk,
  input  logic [1:0] en,
  input  logic [7:0] vl,
  input  logic [7:0] hl,
  input  logic [7:0] base,
  input  logic [7:0] y_in,
  input  logic [7:0] cb_in,
  input  logic [7:0] cr_in,
  output logic [7:0] luma_out,
  output logic [7:0] blue_out,
  output logic [7:0] red_out,
  output logic       painted
);
  import hgo_pkg::*;

  logic [7:0]         lv;
  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic               paint1;
  logic [7:0]         y1, cb1, cr1;
  logic [15:0]        mag;
  logic [7:0]         q;

  assign lv   = (vl != 8'd0) ? vl : hl;
  assign diff = signed'({1'b0, base}) - 9'sd128;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod   <= diff * signed'({1'b0, lv});
      paint1 <= lv != 8'd0;
      y1     <= y_in;
      cb1    <= cb_in;
      cr1    <= cr_in;
    end
  end

  // truncating divide by 255 on the magnitude
  assign mag = prod[17] ? 16'(-prod) : prod[15:0];
  assign q   = div255(mag);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      painted <= paint1;
      if (paint1) begin
        luma_out <= prod[17] ? 8'd128 - q : 8'd128 + q;
        blue_out <= 8'd128;
        red_out  <= 8'd128;
      end else begin
        luma_out <= y1;
        blue_out <= cb1;
        red_out  <= cr1;
      end
    end
  end

endmodule

### rtl/hashed_grid_overlay_pixel_unit.sv
`timescale 1ns / 1ps
// Hashed grid overlay: paints a grid of neutral-chroma lines over a YCbCr
// pixel stream. Throughput is one pixel per clock while out_stall is low. The
// pipe is 1 input register, 6 divider stages at 2 quotient bits each, 9 hash
// and level stages, and 2 blend stages.
// Every stage carries its own valid bit and takes new data whenever it is
// empty or its successor moves, so bubbles close up under out_stall and the
// input keeps accepting until the pipe is full. Configuration writes are
// accepted at any time (cfg_ready is tied high) but should be issued only
// while the pipe is empty; after a write the derived pitch terms pass through
// the pitch_q register and then the pitch_term register.
module hashed_grid_overlay_pixel_unit #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel in
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [11:0]                 column,
  input  logic [11:0]                 row,
  input  logic [7:0]                  luma_in,
  input  logic [7:0]                  blue_in,
  input  logic [7:0]                  red_in,
  // pixel out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  luma_out,
  output logic [7:0]                  blue_out,
  output logic [7:0]                  red_out,
  output logic                        painted,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hgo_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hgo_pkg::CFG_W-1:0]   cfg_data
);
  import hgo_pkg::*;

  localparam int NSTAGE = 1 + AXIS_STAGES + 2;
  localparam logic [LIMIT_W-1:0] COL_LIMIT = LIMIT_W'(MAX_DIMENSION);

  // ---- configuration registers
  logic [11:0] grid_size;
  logic        white_mode;
  logic [6:0]  horizontal_keep, vertical_keep;
  logic [7:0]  line_blend, dark_luma, bright_luma;
  logic [12:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size       <= 12'd4;
      white_mode      <= 1'b1;
      horizontal_keep <= 7'd100;
      vertical_keep   <= 7'd100;
      line_blend      <= 8'd255;
      frame_height    <= 13'd576;
      dark_luma       <= 8'd16;
      bright_luma     <= 8'd235;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_SIZE:   grid_size       <= cfg_data[11:0];
        REG_WHITE_MODE:  white_mode      <= cfg_data[0];
        REG_H_KEEP:      horizontal_keep <= cfg_data[6:0];
        REG_V_KEEP:      vertical_keep   <= cfg_data[6:0];
        REG_LINE_BLEND:  line_blend      <= cfg_data[7:0];
        REG_FRAME_H:     frame_height    <= cfg_data;
        REG_DARK_LUMA:   dark_luma       <= cfg_data[7:0];
        REG_BRIGHT_LUMA: bright_luma     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---- derived settings: pitch clamp, pitch hash term, damage cliff
  logic [PW-1:0] top_lim, pitch_c, pitch_q;
  logic [31:0]   pitch_term;
  logic [7:0]    cliff;
  logic [15:0]   dsq;
  logic [6:0]    h_den, v_den;
  hgo_shared_t   shared;

  always_comb begin
    top_lim = frame_height[12:2];
    if (top_lim < PW'(4)) top_lim = PW'(4);
    if (grid_size < 12'd4)                  pitch_c = PW'(4);
    else if (grid_size > {1'b0, top_lim})   pitch_c = top_lim;
    else                                    pitch_c = grid_size[PW-1:0];
    dsq   = {8'd0, ~line_blend} * {8'd0, ~line_blend};
    h_den = (horizontal_keep > 7'd100) ? 7'd100 : horizontal_keep;
    v_den = (vertical_keep > 7'd100) ? 7'd100 : vertical_keep;
  end

  always_ff @(posedge clk) begin
    pitch_q    <= pitch_c;
    pitch_term <= 32'({{(32-PW){1'b0}}, pitch_q} * K_P);
    cliff      <= dsq[15:8];
  end

  assign shared = '{pitch: pitch_q, pitch_term: pitch_term,
                    strength: line_blend, cliff: cliff};

  // ---- per-stage valid bits and load enables
  logic [NSTAGE-1:0] v, en;

  always_comb begin
    en[NSTAGE-1] = !v[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE-2; k >= 0; k--) en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= (en & {v[NSTAGE-2:0], in_valid}) | (~en & v);
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NSTAGE-1];

  // ---- input register and pixel delay line
  logic [11:0] col0, row0;
  logic [23:0] pix [0:AXIS_STAGES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      col0   <= column;
      row0   <= row;
      pix[0] <= {luma_in, blue_in, red_in};
    end
    for (int k = 1; k <= AXIS_STAGES; k++) begin
      if (en[k]) pix[k] <= pix[k-1];
    end
  end

  // ---- per-axis line level
  logic [7:0] hl, vl;

  hgo_axis u_row (
    .clk      (clk),
    .en       (en[AXIS_STAGES:1]),
    .coord    (row0),
    .shared   (shared),
    .density  (h_den),
    .limit    ({{(LIMIT_W-13){1'b0}}, frame_height}),
    .vertical (1'b0),
    .level    (hl)
  );

  hgo_axis u_col (
    .clk      (clk),
    .en       (en[AXIS_STAGES:1]),
    .coord    (col0),
    .shared   (shared),
    .density  (v_den),
    .limit    (COL_LIMIT),
    .vertical (1'b1),
    .level    (vl)
  );

  // ---- vertical wins, then blend toward mid-grey
  hgo_blend u_blend (
    .clk      (clk),
    .en       (en[NSTAGE-1:NSTAGE-2]),
    .vl       (vl),
    .hl       (hl),
    .base     (white_mode ? bright_luma : dark_luma),
    .y_in     (pix[AXIS_STAGES][23:16]),
    .cb_in    (pix[AXIS_STAGES][15:8]),
    .cr_in    (pix[AXIS_STAGES][7:0]),
    .luma_out (luma_out),
    .blue_out (blue_out),
    .red_out  (red_out),
    .painted  (painted)
  );

endmodule
